### rtl/core/cos_sim_pkg.sv
package cos_sim_pkg;

    localparam int ELEM_W     = 16;  // signed Q7.8 element
    localparam int SQ_W       = 44;  // sum of squares, unsigned Q28.16
    localparam int DOT_W      = 45;  // dot product, signed Q28.16
    localparam int SQR_P_W    = 31;  // one element squared
    localparam int DOT_P_W    = 32;  // one element product, signed
    localparam int HALF_W     = 23;  // operand slice of the shared multiplier
    localparam int MP_W       = 2 * HALF_W;
    localparam int PROD_W     = 90;  // norm product and squared dot product
    localparam int QUO_W      = 32;  // saturated quotient, radicand of the root
    localparam int ROOT_W     = 16;
    localparam int SIM_W      = 16;  // signed Q1.15
    localparam int CNT_W      = 5;

    localparam int MUL_STEPS  = 8;   // 4 partial products for each of two squares
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = QUO_W / 2;

    // multiplier step code: bit 2 selects the operand pair, bits 1:0 the slices
    localparam int MSTEP_W    = 3;
    localparam int MSTEP_DOT  = 2;   // bit index: 0 = norm product, 1 = dot squared

    typedef struct packed {
        logic               accept;
        logic               start;
        logic               mul_go;
        logic [MSTEP_W-1:0] mul_step;
        logic               div_init;
        logic               div_step;
        logic               root_step;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_pending;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/cosine_similarity_stream.sv
// Cosine similarity of two streamed vectors. Each request carries one element of
// each vector (signed Q7.8) and tlast on the final pair; a pair is taken every
// cycle while the vector streams in, with the sums of squares and the dot product
// accumulated from the registered products. After the last pair the input
// stalls while the result is formed: eight steps of a shared 23x23 multiplier
// build the product of the squared norms and the squared dot product, a 32-step
// restoring divider and a 16-step integer square root follow. The result is signed
// Q1.15, rounded to nearest with ties away from zero and saturated to 32767 /
// -32768; if either vector has zero norm the result is 0 with tuser set. A
// finished result sits in an output register and the next vector is taken as
// soon as that register is loaded.
module cosine_similarity_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        i_s_tlast,   // last pair of both vectors
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] similarity
    output logic        o_m_tuser    // [0] zero_norm
);

    cos_sim_pkg::t_dp_cmd    cmd;
    cos_sim_pkg::t_dp_status status;

    cos_sim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    cos_sim_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_elem_a     (i_s_tdata[15:0]),
        .i_elem_b     (i_s_tdata[31:16]),
        .i_last       (i_s_tlast),
        .i_m_tready   (i_m_tready),
        .o_status     (status),
        .o_m_tvalid   (o_m_tvalid),
        .o_similarity (o_m_tdata),
        .o_zero_norm  (o_m_tuser)
    );

endmodule

### rtl/core/cos_sim_ctrl.sv
module cos_sim_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  cos_sim_pkg::t_dp_status i_status,
    output logic                    o_s_tready,
    output cos_sim_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_ROOT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [cos_sim_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_s_tready = (r_state == ST_ACC) && !i_status.last_pending;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.accept   = i_s_tvalid && o_s_tready;
        o_cmd.mul_step = r_cnt[cos_sim_pkg::MSTEP_W-1:0];
        unique case (r_state)
            ST_ACC: begin
                // last pair is folded in at this edge
                if (i_status.last_pending) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == cos_sim_pkg::CNT_W'(cos_sim_pkg::MUL_STEPS - 1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == cos_sim_pkg::CNT_W'(cos_sim_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == cos_sim_pkg::CNT_W'(cos_sim_pkg::ROOT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/core/cos_sim_dp.sv
module cos_sim_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cos_sim_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [cos_sim_pkg::ELEM_W-1:0]  i_elem_a,
    input  logic signed [cos_sim_pkg::ELEM_W-1:0]  i_elem_b,
    input  logic                                   i_last,
    input  logic                                   i_m_tready,
    output cos_sim_pkg::t_dp_status                o_status,
    output logic                                   o_m_tvalid,
    output logic [cos_sim_pkg::SIM_W-1:0]          o_similarity,
    output logic                                   o_zero_norm
);

    localparam int HW = cos_sim_pkg::HALF_W;
    localparam int PW = cos_sim_pkg::PROD_W;
    localparam int QW = cos_sim_pkg::QUO_W;

    // product stage
    logic                                 r_p_valid, r_p_last;
    logic [cos_sim_pkg::SQR_P_W-1:0]      r_sq_a, r_sq_b;
    logic signed [cos_sim_pkg::DOT_P_W-1:0] r_dot_p;
    logic signed [cos_sim_pkg::DOT_P_W-1:0] n_sq_a, n_sq_b, n_dot_p;

    // accumulators
    logic [cos_sim_pkg::SQ_W-1:0]  r_sum_a, r_sum_b, n_sum_a, n_sum_b;
    logic [cos_sim_pkg::DOT_W-1:0] r_dot, n_dot;
    logic [cos_sim_pkg::SQ_W:0]    sum_a_ext, sum_b_ext;
    logic [cos_sim_pkg::DOT_W:0]   dot_ext;

    // shared multiplier
    logic [cos_sim_pkg::DOT_W-1:0] dmag;
    logic [HW-1:0]                 sa_lo, sa_hi, sb_lo, sb_hi, d_lo, d_hi, mul_x, mul_y;
    logic [cos_sim_pkg::MP_W-1:0]  r_pp;
    logic                          r_pp_valid, r_pp_dot;
    logic [1:0]                    r_pp_sh, n_pp_sh;
    logic [PW-1:0]                 pp_aligned;
    logic [PW-1:0]                 r_prod_p, r_prod_d;

    // divider and root
    logic          r_sat;
    logic [PW-1:0] r_rem, rem_shift;
    logic [QW-1:0] r_q, r_res, r_one, root_trial;

    // result
    logic [cos_sim_pkg::ROOT_W:0]   root_inc;
    logic [cos_sim_pkg::SIM_W-1:0]  mag, n_sim;
    logic                           zero_in;

    assign n_sq_a  = i_elem_a * i_elem_a;
    assign n_sq_b  = i_elem_b * i_elem_b;
    assign n_dot_p = i_elem_a * i_elem_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.accept;
            r_p_last  <= i_cmd.accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sq_a  <= n_sq_a[cos_sim_pkg::SQR_P_W-1:0];
            r_sq_b  <= n_sq_b[cos_sim_pkg::SQR_P_W-1:0];
            r_dot_p <= n_dot_p;
        end
    end

    // saturating accumulate
    always_comb begin
        sum_a_ext = {1'b0, r_sum_a} + (cos_sim_pkg::SQ_W + 1)'(r_sq_a);
        sum_b_ext = {1'b0, r_sum_b} + (cos_sim_pkg::SQ_W + 1)'(r_sq_b);
        dot_ext   = {r_dot[cos_sim_pkg::DOT_W-1], r_dot}
                  + {{(cos_sim_pkg::DOT_W + 1 - cos_sim_pkg::DOT_P_W){r_dot_p[cos_sim_pkg::DOT_P_W-1]}},
                     r_dot_p};
        n_sum_a = sum_a_ext[cos_sim_pkg::SQ_W] ? '1 : sum_a_ext[cos_sim_pkg::SQ_W-1:0];
        n_sum_b = sum_b_ext[cos_sim_pkg::SQ_W] ? '1 : sum_b_ext[cos_sim_pkg::SQ_W-1:0];
        priority if (!dot_ext[cos_sim_pkg::DOT_W] && dot_ext[cos_sim_pkg::DOT_W-1]) begin
            n_dot = {1'b0, {(cos_sim_pkg::DOT_W-1){1'b1}}};
        end else if (dot_ext[cos_sim_pkg::DOT_W] && !dot_ext[cos_sim_pkg::DOT_W-1]) begin
            n_dot = {1'b1, {(cos_sim_pkg::DOT_W-1){1'b0}}};
        end else begin
            n_dot = dot_ext[cos_sim_pkg::DOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_dot   <= '0;
        end else if (i_cmd.out_load) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_dot   <= '0;
        end else if (r_p_valid) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_dot   <= n_dot;
        end
    end

    // |dot| needs 45 bits: the negative limit has no positive twin
    assign dmag  = r_dot[cos_sim_pkg::DOT_W-1] ? (~r_dot + 1'b1) : r_dot;
    assign sa_lo = r_sum_a[HW-1:0];
    assign sa_hi = HW'(r_sum_a[cos_sim_pkg::SQ_W-1:HW]);
    assign sb_lo = r_sum_b[HW-1:0];
    assign sb_hi = HW'(r_sum_b[cos_sim_pkg::SQ_W-1:HW]);
    assign d_lo  = dmag[HW-1:0];
    assign d_hi  = HW'(dmag[cos_sim_pkg::DOT_W-1:HW]);

    always_comb begin
        if (i_cmd.mul_step[cos_sim_pkg::MSTEP_DOT]) begin
            mul_x = i_cmd.mul_step[1] ? d_hi : d_lo;
            mul_y = i_cmd.mul_step[0] ? d_hi : d_lo;
        end else begin
            mul_x = i_cmd.mul_step[1] ? sa_hi : sa_lo;
            mul_y = i_cmd.mul_step[0] ? sb_hi : sb_lo;
        end
        n_pp_sh = {1'b0, i_cmd.mul_step[1]} + {1'b0, i_cmd.mul_step[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
        end else begin
            r_pp_valid <= i_cmd.mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_pp     <= mul_x * mul_y;
            r_pp_dot <= i_cmd.mul_step[cos_sim_pkg::MSTEP_DOT];
            r_pp_sh  <= n_pp_sh;
        end
    end

    // high x high slices are at most 44 bits wide
    always_comb begin
        unique case (r_pp_sh)
            2'd0:    pp_aligned = {{(PW - cos_sim_pkg::MP_W){1'b0}}, r_pp};
            2'd1:    pp_aligned = {{(PW - cos_sim_pkg::MP_W - HW){1'b0}}, r_pp, {HW{1'b0}}};
            2'd2:    pp_aligned = {r_pp[PW-2*HW-1:0], {(2*HW){1'b0}}};
            default: pp_aligned = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_prod_p <= '0;
            r_prod_d <= '0;
        end else if (r_pp_valid) begin
            if (r_pp_dot) begin
                r_prod_d <= r_prod_d + pp_aligned;
            end else begin
                r_prod_p <= r_prod_p + pp_aligned;
            end
        end
    end

    // floor(2^32 * d^2 / P) saturated to 32 bits, then its integer root
    assign rem_shift  = {r_rem[PW-2:0], 1'b0};
    assign root_trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_sat <= (r_prod_d >= r_prod_p);
            r_rem <= r_prod_d;
            r_q   <= (r_prod_d >= r_prod_p) ? '1 : '0;
            r_res <= '0;
            r_one <= QW'(1) << (QW - 2);
        end else if (i_cmd.div_step) begin
            if (!r_sat) begin
                if (rem_shift >= r_prod_p) begin
                    r_rem <= rem_shift - r_prod_p;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
        end else if (i_cmd.root_step) begin
            if (r_q >= root_trial) begin
                r_q   <= r_q - root_trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    // largest k with (2k-1) <= root: k = (root + 1) / 2
    assign root_inc = {1'b0, r_res[cos_sim_pkg::ROOT_W-1:0]} + 1'b1;
    assign mag      = root_inc[cos_sim_pkg::ROOT_W:1];
    assign zero_in  = (r_sum_a == '0) || (r_sum_b == '0);

    always_comb begin
        priority if (zero_in) begin
            n_sim = '0;
        end else if (r_dot[cos_sim_pkg::DOT_W-1]) begin
            n_sim = ~mag + 1'b1;
        end else if (mag[cos_sim_pkg::SIM_W-1]) begin
            n_sim = {1'b0, {(cos_sim_pkg::SIM_W-1){1'b1}}};
        end else begin
            n_sim = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_similarity <= n_sim;
            o_zero_norm  <= zero_in;
        end
    end

    assign o_status.last_pending = r_p_valid && r_p_last;
    assign o_status.out_free     = !o_m_tvalid || i_m_tready;

endmodule

### rtl/core/cos_sim_checker.sv
module cos_sim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // input is held off while the quotient is formed
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready ##1 !o_s_tready)
        else $error("input taken right after a last request");

    a_zero_norm_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 16'h0000))
        else $error("zero norm result with nonzero similarity");

    // a new result only comes out of the busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared while input was open");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind cosine_similarity_stream cos_sim_checker u_cos_sim_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### verif/cosine_similarity_stream_tb.sv
module cosine_similarity_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SETTLE     = 80;
    localparam int  LONG_HOLD  = 800;
    localparam int  RAND_ITEMS = 220;  // per random phase
    localparam longint SQ_CAP  = (longint'(1) << cos_sim_pkg::SQ_W) - 1;
    localparam longint DOT_HI  = (longint'(1) << (cos_sim_pkg::DOT_W - 1)) - 1;
    localparam longint DOT_LO  = -(longint'(1) << (cos_sim_pkg::DOT_W - 1));

    typedef struct {
        logic signed [cos_sim_pkg::ELEM_W-1:0] a;
        logic signed [cos_sim_pkg::ELEM_W-1:0] b;
        logic                                  last;
    } t_pair;

    typedef struct {
        logic [cos_sim_pkg::SIM_W-1:0] similarity;
        logic                          zero_norm;
    } t_cos_result;

    typedef enum {
        VS_RAND, VS_SMALL, VS_SAME, VS_NEG, VS_SCALED, VS_ZERO_A, VS_ZERO_B, VS_SPARSE
    } t_vec_style;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [15:0] elem_a, [31:16] elem_b
    logic        i_s_tlast  = 1'b0; // last pair of both vectors
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [15:0] similarity
    logic        o_m_tuser;         // [0] zero_norm

    t_pair       pair_q[$];
    t_pair       cur_pair;
    t_cos_result cos_expect_q[$];

    // predictor accumulators
    longint      acc_aa = 0;
    longint      acc_bb = 0;
    longint      acc_ab = 0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;

    int          n_errors = 0;
    int          n_pairs = 0;
    int          n_vectors = 0;
    int          n_results = 0;
    int          n_zero_norm = 0;
    int          n_clipped = 0;

    cosine_similarity_stream u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // rounded magnitude: largest k with k == 0 or (2k-1)^2 * sa * sb <= 2^32 * dot^2
    function automatic logic [cos_sim_pkg::SIM_W-1:0] cos_q15(longint sa, longint sb,
                                                             longint dot);
        logic [127:0] norm_prod;
        logic [127:0] dot_sq;
        logic [127:0] t;
        logic [63:0]  dmag;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        longint       sim;
        dmag = (dot < 0) ? 64'(-dot) : 64'(dot);
        norm_prod = 128'(64'(sa)) * 128'(64'(sb));
        dot_sq = (128'(dmag) * 128'(dmag)) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 128'(2 * mid - 1);
            if (norm_prod * t * t <= dot_sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot < 0)
            sim = -longint'(lo);
        else
            sim = (lo > 32767) ? 32767 : longint'(lo);
        return sim[cos_sim_pkg::SIM_W-1:0];
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic void absorb_pair(t_pair p);
        t_cos_result r;
        acc_aa = sat(acc_aa + longint'(p.a) * longint'(p.a), 0, SQ_CAP);
        acc_bb = sat(acc_bb + longint'(p.b) * longint'(p.b), 0, SQ_CAP);
        acc_ab = sat(acc_ab + longint'(p.a) * longint'(p.b), DOT_LO, DOT_HI);
        n_pairs++;
        if (!p.last)
            return;
        if (acc_aa == 0 || acc_bb == 0) begin
            r.similarity = '0;
            r.zero_norm  = 1'b1;
            n_zero_norm++;
        end else begin
            r.similarity = cos_q15(acc_aa, acc_bb, acc_ab);
            r.zero_norm  = 1'b0;
            if (r.similarity == 16'h7FFF || r.similarity == 16'h8000)
                n_clipped++;
        end
        cos_expect_q.push_back(r);
        n_vectors++;
        acc_aa = 0;
        acc_bb = 0;
        acc_ab = 0;
    endfunction

    // driver: valid stays up until the request is taken
    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            busy = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                absorb_pair(cur_pair);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pair_q.size() != 0 && !roll(send_idle_pct)) begin
                    cur_pair = pair_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_pair.b, cur_pair.a};
                    i_s_tlast  <= cur_pair.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= hold_left == 0 && hold_req == hold_ack && !roll(recv_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_cos_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (cos_expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result sim=%0d zero_norm=%0b",
                             $signed(o_m_tdata), o_m_tuser);
            end else begin
                want = cos_expect_q.pop_front();
                if (o_m_tdata !== want.similarity || o_m_tuser !== want.zero_norm) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d: sim exp %0d got %0d, zero_norm exp %0b got %0b",
                                 n_results, $signed(want.similarity), $signed(o_m_tdata),
                                 want.zero_norm, o_m_tuser);
                end
            end
        end
    end

    function automatic void push_pair(logic [15:0] a, logic [15:0] b, logic last);
        t_pair p;
        p.a    = a;
        p.b    = b;
        p.last = last;
        pair_q.push_back(p);
    endfunction

    function automatic void queue_vector(int len, t_vec_style style);
        logic signed [15:0] a;
        logic signed [15:0] b;
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (style)
                VS_SMALL: begin
                    a = $signed(16'($urandom_range(64, 0))) - 16'sd32;
                    b = $signed(16'($urandom_range(64, 0))) - 16'sd32;
                end
                VS_SAME:   b = a;
                VS_NEG:    b = -a;
                VS_SCALED: b = a >>> $urandom_range(6, 1);
                VS_ZERO_A: a = '0;
                VS_ZERO_B: b = '0;
                VS_SPARSE: begin
                    if (roll(50)) a = '0;
                    if (roll(50)) b = '0;
                end
                default: ;
            endcase
            push_pair(a, b, i == len - 1);
        end
    endfunction

    function automatic void queue_random_vectors(int budget);
        int added;
        int len;
        added = 0;
        while (added < budget) begin
            if (roll(3))
                len = $urandom_range(300, 65);
            else if (roll(10))
                len = $urandom_range(64, 13);
            else
                len = $urandom_range(12, 1);
            queue_vector(len, t_vec_style'($urandom_range(7, 0)));
            added += len;
        end
    endfunction

    task automatic drain();
        do @(negedge i_clk);
        while (pair_q.size() != 0 || i_s_tvalid || cos_expect_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_vectors(RAND_ITEMS);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero norms, orthogonal and cancelling vectors
        push_pair(16'h7FFF, 16'h7FFF, 1'b1);
        push_pair(16'h8000, 16'h8000, 1'b1);
        push_pair(16'h8000, 16'h7FFF, 1'b1);
        push_pair(16'h0001, 16'hFFFF, 1'b1);
        push_pair(16'h0000, 16'h1234, 1'b1);
        push_pair(16'h1234, 16'h0000, 1'b1);
        push_pair(16'h0000, 16'h0000, 1'b1);
        push_pair(16'h0100, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'h0100, 1'b1);
        push_pair(16'h0100, 16'h0100, 1'b0);
        push_pair(16'h0100, 16'hFF00, 1'b1);
        push_pair(16'h5555, 16'hAAAA, 1'b0);
        push_pair(16'hAAAA, 16'h5555, 1'b1);
        push_pair(16'hFFFF, 16'h0001, 1'b0);
        push_pair(16'h0002, 16'h0003, 1'b0);
        push_pair(16'h7FFF, 16'h8001, 1'b1);
        drain();

        random_phase(0, 0);
        random_phase(79, 0);
        random_phase(0, 79);
        random_phase(7, 7);

        // receiver holds off while short vectors keep coming: input must stall
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 40; i++)
            queue_vector($urandom_range(4, 1), t_vec_style'($urandom_range(7, 0)));
        hold_req = ~hold_req;
        drain();

        $display("Covered %0d vectors (%0d pairs): %0d zero-norm, %0d at +/-1.0,",
                 n_vectors, n_pairs, n_zero_norm, n_clipped);
        $display("under sender gaps, receiver stalls and a long receiver hold-off.");
        if (n_errors == 0 && cos_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", cos_expect_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/core/cos_sim_pkg.sv
rtl/core/cos_sim_ctrl.sv
rtl/core/cos_sim_dp.sv
rtl/core/cosine_similarity_stream.sv
rtl/core/cos_sim_checker.sv
verif/cosine_similarity_stream_tb.sv
